@@ rtl/core/bgcr_pkg.sv @@
// Shared types and constants for the bitmap glyph column renderer.
`timescale 1ns / 1ps
`default_nettype none
package bgcr_pkg;

    localparam int FIRST_CODE     = 32;
    localparam int GLYPH_COUNT    = 96;
    localparam int GLYPH_COLUMNS  = 19;
    localparam int GLYPH_ROWS     = 21;
    localparam int COL_BYTES      = (GLYPH_ROWS + 7) / 8;
    localparam int RECORD_BYTES   = 1 + GLYPH_COLUMNS * COL_BYTES;
    localparam int STORE_DEPTH    = GLYPH_COUNT * RECORD_BYTES;
    localparam int MASK_ROWS      = 24;
    localparam int VRAM_LIMIT     = 393215;
    localparam int SCREEN_WIDTH_RESET = 480;

    localparam int STORE_ADDR_W   = 13;
    localparam int BYTE_W         = 8;
    localparam int STRIDE_W       = 11;
    localparam int POS_W          = 10;
    localparam int COLOR_W        = 8;
    localparam int CODE_W         = 8;
    localparam int COL_ADDR_W     = 21;
    localparam int ROW_ADDR_W     = 22;
    localparam int PROD_W         = STRIDE_W + POS_W;
    localparam int GLYPH_IDX_W    = $clog2(GLYPH_COUNT);
    localparam int COL_CNT_W      = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
    localparam int ROW_CNT_W      = $clog2(MASK_ROWS);
    localparam int ROW_NUM_W      = $clog2(MASK_ROWS + 1);

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_BASE,
        ST_LIMIT,
        ST_COL0,
        ST_COL1,
        ST_COL2,
        ST_EMIT,
        ST_BAD
    } state_t;

    typedef struct packed {
        logic                  start;
        logic                  step;
        logic [ROW_ADDR_W-1:0] addr;
    } lim_ctl_t;

    typedef struct packed {
        logic                 busy;
        logic [MASK_ROWS-1:0] thermo;
    } lim_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/bgcr_req_if.sv @@
// Request channel interface: font loads and render commands.
`timescale 1ns / 1ps
`default_nettype none
interface bgcr_req_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [bgcr_pkg::STORE_ADDR_W-1:0]  font_index;
    logic [bgcr_pkg::BYTE_W-1:0]        font_byte;
    logic [bgcr_pkg::POS_W-1:0]         pos_x;
    logic [bgcr_pkg::POS_W-1:0]         pos_y;
    logic [bgcr_pkg::COLOR_W-1:0]       pixel_color;
    logic [bgcr_pkg::CODE_W-1:0]        char_code;

    modport source (
        output valid, command, font_index, font_byte, pos_x, pos_y, pixel_color, char_code,
        input  ready
    );
    modport sink (
        input  valid, command, font_index, font_byte, pos_x, pos_y, pixel_color, char_code,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/core/bgcr_res_if.sv @@
// Result channel interface: one glyph column per item.
`timescale 1ns / 1ps
`default_nettype none
interface bgcr_res_if;
    logic                               valid;
    logic                               ready;
    logic [bgcr_pkg::COL_ADDR_W-1:0]    column_address;
    logic [bgcr_pkg::MASK_ROWS-1:0]     row_mask;
    logic [bgcr_pkg::COLOR_W-1:0]       out_color;
    logic [bgcr_pkg::BYTE_W-1:0]        advance;
    logic                               bad_code;
    logic                               last;

    modport source (
        output valid, column_address, row_mask, out_color, advance, bad_code, last,
        input  ready
    );
    modport sink (
        input  valid, column_address, row_mask, out_color, advance, bad_code, last,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/core/bgcr_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bgcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 5568,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/bgcr_rowlim.sv @@
// Row limit tracker: count of glyph rows that stay inside the frame buffer.
`timescale 1ns / 1ps
`default_nettype none
module bgcr_rowlim (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [bgcr_pkg::STRIDE_W-1:0]     stride,
    input  wire bgcr_pkg::lim_ctl_t                ctl,
    output      bgcr_pkg::lim_sts_t                sts
);

    localparam logic [bgcr_pkg::ROW_ADDR_W-1:0] LIMIT_ADDR =
        bgcr_pkg::ROW_ADDR_W'(bgcr_pkg::VRAM_LIMIT);
    localparam logic [bgcr_pkg::ROW_CNT_W-1:0] LAST_ROW =
        bgcr_pkg::ROW_CNT_W'(bgcr_pkg::MASK_ROWS - 1);

    logic                              busy_reg,  busy_next;
    logic [bgcr_pkg::ROW_CNT_W-1:0]    row_reg,   row_next;
    logic [bgcr_pkg::ROW_NUM_W-1:0]    k_reg,     k_next;
    logic [bgcr_pkg::ROW_ADDR_W-1:0]   probe_reg, probe_next;
    logic [bgcr_pkg::ROW_ADDR_W-1:0]   edge_reg,  edge_next;
    logic [bgcr_pkg::ROW_ADDR_W-1:0]   stride_ext;
    logic [bgcr_pkg::ROW_ADDR_W-1:0]   edge_inc;

    assign stride_ext = bgcr_pkg::ROW_ADDR_W'(stride);
    assign edge_inc   = edge_reg + bgcr_pkg::ROW_ADDR_W'(1);

    always_comb
    begin
        busy_next  = busy_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        probe_next = probe_reg;
        edge_next  = edge_reg;
        priority if (ctl.start)
        begin
            busy_next  = 1'b1;
            row_next   = '0;
            k_next     = '0;
            probe_next = ctl.addr;
        end
        else if (busy_reg)
        begin
            if (probe_reg <= LIMIT_ADDR)
            begin
                k_next    = bgcr_pkg::ROW_NUM_W'(row_reg) + bgcr_pkg::ROW_NUM_W'(1);
                edge_next = probe_reg;
            end
            probe_next = probe_reg + stride_ext;
            if (row_reg == LAST_ROW)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + bgcr_pkg::ROW_CNT_W'(1);
            end
        end
        else if (ctl.step && (k_reg != '0))
        begin
            if (edge_inc > LIMIT_ADDR)
            begin
                if ((stride == '0) || (k_reg == bgcr_pkg::ROW_NUM_W'(1)))
                begin
                    k_next = '0;
                end
                else
                begin
                    k_next    = k_reg - bgcr_pkg::ROW_NUM_W'(1);
                    edge_next = edge_inc - stride_ext;
                end
            end
            else
            begin
                edge_next = edge_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        edge_reg  <= edge_next;
    end

    always_comb
    begin
        sts.busy = busy_reg;
        for (int j = 0; j < bgcr_pkg::MASK_ROWS; j++)
        begin
            sts.thermo[j] = (bgcr_pkg::ROW_NUM_W'(j) < k_reg);
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/bitmap_glyph_column_renderer.sv @@
// Top level of the bitmap glyph column renderer: sequencer, font store, row limit tracker and output register.
//
// Usage:
//   request carries one item per valid/ready handshake. command 0 writes font_byte
//   into the font store at font_index (writes past the store are dropped). command 1
//   renders char_code at (pos_x, pos_y) in pixel_color.
//   result carries one item per glyph column, left to right, with last set on the
//   final column. A code outside the font gives a single item with bad_code and last.
//   cfg_wr_en / cfg_wr_data write screen_width; write it only while the block is idle.
// Sequence:
//   A render passes the setup states ST_SETUP and ST_BASE, then a scan of the 24 row
//   addresses of the first column against the frame-buffer limit, then three font
//   store reads per column on the single read port.
//   request is ready only between items; a finished item in the output register
//   does not block the next request.
// Stall:
//   While result.ready is low the output register holds and the sequencer waits.
// Reset:
//   Control clears and screen_width returns to 480. The font store is undefined
//   until loaded.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_glyph_column_renderer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bgcr_pkg::STRIDE_W-1:0] cfg_wr_data,
    bgcr_req_if.sink                           request,
    bgcr_res_if.source                         result
);

    localparam logic [bgcr_pkg::COL_CNT_W-1:0] LAST_COL =
        bgcr_pkg::COL_CNT_W'(bgcr_pkg::GLYPH_COLUMNS - 1);

    bgcr_pkg::state_t                      state_reg, state_next;
    logic [bgcr_pkg::STRIDE_W-1:0]         stride_reg;
    logic [bgcr_pkg::STORE_ADDR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bgcr_pkg::COL_CNT_W-1:0]        col_cnt_reg, col_cnt_next;
    logic [bgcr_pkg::POS_W-1:0]            px_reg;
    logic [bgcr_pkg::POS_W-1:0]            py_reg;
    logic [bgcr_pkg::COLOR_W-1:0]          color_reg;
    logic [bgcr_pkg::GLYPH_IDX_W-1:0]      glyph_reg;
    logic [bgcr_pkg::PROD_W-1:0]           prod_reg;
    logic [bgcr_pkg::ROW_ADDR_W-1:0]       col_addr_reg;
    logic [bgcr_pkg::BYTE_W-1:0]           adv_reg;
    logic [bgcr_pkg::MASK_ROWS-1:0]        col_bits_reg;

    logic                                  out_valid_reg;
    logic [bgcr_pkg::COL_ADDR_W-1:0]       out_addr_reg;
    logic [bgcr_pkg::MASK_ROWS-1:0]        out_mask_reg;
    logic [bgcr_pkg::COLOR_W-1:0]          out_color_reg;
    logic [bgcr_pkg::BYTE_W-1:0]           out_adv_reg;
    logic                                  out_bad_reg;
    logic                                  out_last_reg;

    logic                                  out_free;
    logic                                  out_load;
    logic                                  out_bad;
    logic                                  take_render;
    logic                                  code_ok;
    logic [bgcr_pkg::CODE_W-1:0]           code_off;
    logic                                  ram_we;
    logic                                  ram_re;
    logic [bgcr_pkg::BYTE_W-1:0]           ram_rdata;
    logic [bgcr_pkg::ROW_ADDR_W-1:0]       start_addr;
    logic [bgcr_pkg::MASK_ROWS-1:0]        col_mask;
    logic                                  last_col;
    bgcr_pkg::lim_ctl_t                    lim_ctl;
    bgcr_pkg::lim_sts_t                    lim_sts;

    assign code_off = request.char_code - bgcr_pkg::CODE_W'(bgcr_pkg::FIRST_CODE);
    assign code_ok  = (request.char_code >= bgcr_pkg::CODE_W'(bgcr_pkg::FIRST_CODE)) &&
                      (code_off < bgcr_pkg::CODE_W'(bgcr_pkg::GLYPH_COUNT));
    assign out_free   = !out_valid_reg || result.ready;
    assign start_addr = bgcr_pkg::ROW_ADDR_W'(prod_reg) + bgcr_pkg::ROW_ADDR_W'(px_reg);
    assign col_mask   = {ram_rdata, col_bits_reg[bgcr_pkg::MASK_ROWS-1:bgcr_pkg::BYTE_W]}
                        & lim_sts.thermo;
    assign last_col   = (col_cnt_reg == LAST_COL);

    bgcr_ram #(
        .WIDTH (bgcr_pkg::BYTE_W),
        .DEPTH (bgcr_pkg::STORE_DEPTH)
    ) u_font_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (request.font_index),
        .wdata (request.font_byte),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    bgcr_rowlim u_rowlim (
        .clk    (clk),
        .rst_n  (rst_n),
        .stride (stride_reg),
        .ctl    (lim_ctl),
        .sts    (lim_sts)
    );

    always_comb
    begin
        state_next    = state_reg;
        rd_ptr_next   = rd_ptr_reg;
        col_cnt_next  = col_cnt_reg;
        request.ready = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        take_render   = 1'b0;
        out_load      = 1'b0;
        out_bad       = 1'b0;
        lim_ctl       = '0;
        unique case (state_reg)
            bgcr_pkg::ST_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                begin
                    if (request.command == bgcr_pkg::CMD_LOAD)
                    begin
                        ram_we = (request.font_index <
                                  bgcr_pkg::STORE_ADDR_W'(bgcr_pkg::STORE_DEPTH));
                    end
                    else if (code_ok)
                    begin
                        take_render = 1'b1;
                        state_next  = bgcr_pkg::ST_SETUP;
                    end
                    else
                    begin
                        state_next = bgcr_pkg::ST_BAD;
                    end
                end
            end
            bgcr_pkg::ST_SETUP:
            begin
                rd_ptr_next = bgcr_pkg::STORE_ADDR_W'(glyph_reg * bgcr_pkg::RECORD_BYTES);
                state_next  = bgcr_pkg::ST_BASE;
            end
            bgcr_pkg::ST_BASE:
            begin
                ram_re        = 1'b1;
                rd_ptr_next   = rd_ptr_reg + bgcr_pkg::STORE_ADDR_W'(1);
                lim_ctl.start = 1'b1;
                lim_ctl.addr  = start_addr;
                col_cnt_next  = '0;
                state_next    = bgcr_pkg::ST_LIMIT;
            end
            bgcr_pkg::ST_LIMIT:
            begin
                if (!lim_sts.busy)
                begin
                    state_next = bgcr_pkg::ST_COL0;
                end
            end
            bgcr_pkg::ST_COL0:
            begin
                ram_re      = 1'b1;
                rd_ptr_next = rd_ptr_reg + bgcr_pkg::STORE_ADDR_W'(1);
                state_next  = bgcr_pkg::ST_COL1;
            end
            bgcr_pkg::ST_COL1:
            begin
                ram_re      = 1'b1;
                rd_ptr_next = rd_ptr_reg + bgcr_pkg::STORE_ADDR_W'(1);
                state_next  = bgcr_pkg::ST_COL2;
            end
            bgcr_pkg::ST_COL2:
            begin
                ram_re      = 1'b1;
                rd_ptr_next = rd_ptr_reg + bgcr_pkg::STORE_ADDR_W'(1);
                state_next  = bgcr_pkg::ST_EMIT;
            end
            bgcr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    lim_ctl.step = 1'b1;
                    if (last_col)
                    begin
                        state_next = bgcr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + bgcr_pkg::COL_CNT_W'(1);
                        ram_re       = 1'b1;
                        rd_ptr_next  = rd_ptr_reg + bgcr_pkg::STORE_ADDR_W'(1);
                        state_next   = bgcr_pkg::ST_COL1;
                    end
                end
            end
            bgcr_pkg::ST_BAD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_bad    = 1'b1;
                    state_next = bgcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bgcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bgcr_pkg::ST_IDLE;
            stride_reg    <= bgcr_pkg::STRIDE_W'(bgcr_pkg::SCREEN_WIDTH_RESET);
            col_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_cnt_reg <= col_cnt_next;
            if (cfg_wr_en)
            begin
                stride_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        if (take_render)
        begin
            px_reg    <= request.pos_x;
            py_reg    <= request.pos_y;
            color_reg <= request.pixel_color;
            glyph_reg <= bgcr_pkg::GLYPH_IDX_W'(code_off);
        end
        if (state_reg == bgcr_pkg::ST_SETUP)
        begin
            prod_reg <= bgcr_pkg::PROD_W'(stride_reg) * bgcr_pkg::PROD_W'(py_reg);
        end
        if (state_reg == bgcr_pkg::ST_BASE)
        begin
            col_addr_reg <= start_addr;
        end
        else if (out_load && !out_bad)
        begin
            col_addr_reg <= col_addr_reg + bgcr_pkg::ROW_ADDR_W'(1);
        end
        if (state_reg == bgcr_pkg::ST_LIMIT)
        begin
            adv_reg <= ram_rdata;
        end
        if ((state_reg == bgcr_pkg::ST_COL1) || (state_reg == bgcr_pkg::ST_COL2))
        begin
            col_bits_reg <= {ram_rdata, col_bits_reg[bgcr_pkg::MASK_ROWS-1:bgcr_pkg::BYTE_W]};
        end
        if (out_load)
        begin
            if (out_bad)
            begin
                out_addr_reg  <= '0;
                out_mask_reg  <= '0;
                out_color_reg <= '0;
                out_adv_reg   <= '0;
                out_bad_reg   <= 1'b1;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_addr_reg  <= col_addr_reg[bgcr_pkg::COL_ADDR_W-1:0];
                out_mask_reg  <= col_mask;
                out_color_reg <= color_reg;
                out_adv_reg   <= adv_reg;
                out_bad_reg   <= 1'b0;
                out_last_reg  <= last_col;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.column_address = out_addr_reg;
    assign result.row_mask       = out_mask_reg;
    assign result.out_color      = out_color_reg;
    assign result.advance        = out_adv_reg;
    assign result.bad_code       = out_bad_reg;
    assign result.last           = out_last_reg;

endmodule
`default_nettype wire
